// ===== hw/rtl/pjhsp_pkg.sv =====
package pjhsp_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 48;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FILE_SIZE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SIDE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PIXEL_COUNT = 2'd2;

  localparam logic [31:0] MAX_FILE_SIZE_RST = 32'd33554432;
  localparam logic [31:0] MAX_SIDE_RST = 32'd16384;
  localparam logic [47:0] MAX_PIXEL_COUNT_RST = 48'd67108864;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_LIMITS = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_HEADER = 3'd3;
  localparam logic [2:0] ST_DIMS = 3'd4;

  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_PNG = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_PNG = 4'd1;
  localparam logic [3:0] PH_SOI2 = 4'd2;
  localparam logic [3:0] PH_SCAN = 4'd3;
  localparam logic [3:0] PH_FILL = 4'd4;
  localparam logic [3:0] PH_LEN_HI = 4'd5;
  localparam logic [3:0] PH_LEN_LO = 4'd6;
  localparam logic [3:0] PH_SOF_LEN_HI = 4'd7;
  localparam logic [3:0] PH_SOF_LEN_LO = 4'd8;
  localparam logic [3:0] PH_SKIP = 4'd9;
  localparam logic [3:0] PH_SOF_BODY = 4'd10;
  localparam logic [3:0] PH_IDLE = 4'd11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  image_format;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } out_beat_t;

  // Summary of one file, handed from the parser to the checker.
  typedef struct packed {
    logic        hdr_ok;
    logic        count_bad;
    logic [1:0]  fmt;
    logic [31:0] width;
    logic [31:0] height;
  } file_sum_t;

  function automatic logic [7:0] png_head(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd0: v = 8'h89;
      4'd1: v = 8'h50;
      4'd2: v = 8'h4e;
      4'd3: v = 8'h47;
      4'd4: v = 8'h0d;
      4'd5: v = 8'h0a;
      4'd6: v = 8'h1a;
      4'd7: v = 8'h0a;
      4'd8, 4'd9, 4'd10: v = 8'h00;
      4'd11: v = 8'd13;
      4'd12: v = 8'h49;
      4'd13: v = 8'h48;
      4'd14: v = 8'h44;
      default: v = 8'h52;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/pjhsp_parser.sv =====
module pjhsp_parser #(
  parameter int COUNT_BITS = pjhsp_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  pjhsp_pkg::in_beat_t   in_data,
  input  logic [31:0]           max_file_size,
  output logic                  sum_valid,
  input  logic                  sum_full,
  output pjhsp_pkg::file_sum_t  sum_data
);

  localparam int EB = COUNT_BITS + 1;
  localparam int CW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [3:0]  ph_r, ph_nxt;
  logic        fail_r, fail_nxt, found_r, found_nxt;
  logic [15:0] left_r, left_nxt;
  logic [2:0]  off_r, off_nxt;
  logic [EB-1:0] end_r, end_nxt;
  logic [31:0] w_r, w_nxt, h_r, h_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [7:0]  b;
  logic [15:0] size;
  logic        fire, is_sof;
  logic [EB-1:0] cnt_ext;
  logic [CW-1:0] cnt_big;
  logic        hdr_ok;

  assign b = in_data.data_byte;
  assign in_full = sum_full;
  assign fire = in_push && !sum_full;
  assign size = {left_r[7:0], b};
  assign is_sof = (b[7:4] == 4'hc) && (b != 8'hc4) && (b != 8'hc8) && (b != 8'hcc);

  always_comb begin
    cnt_nxt = cnt_r; ph_nxt = ph_r; fail_nxt = fail_r; found_nxt = found_r;
    left_nxt = left_r; off_nxt = off_r; end_nxt = end_r;
    w_nxt = w_r; h_nxt = h_r; fmt_nxt = fmt_r;
    unique case (ph_r)
      pjhsp_pkg::PH_START: begin
        if (b == 8'h89) begin
          fmt_nxt = pjhsp_pkg::FMT_PNG; ph_nxt = pjhsp_pkg::PH_PNG;
        end else if (b == 8'hff) begin
          fmt_nxt = pjhsp_pkg::FMT_JPEG; ph_nxt = pjhsp_pkg::PH_SOI2;
        end else begin
          fail_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
        end
      end
      pjhsp_pkg::PH_PNG: begin
        if (cnt_r < COUNT_BITS'(16)) begin
          if (b != pjhsp_pkg::png_head(cnt_r[3:0])) begin
            fail_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
          end
        end else if (cnt_r < COUNT_BITS'(20)) begin
          w_nxt = {w_r[23:0], b};
        end else begin
          h_nxt = {h_r[23:0], b};
          if (cnt_r == COUNT_BITS'(23)) begin
            found_nxt = 1'b1; end_nxt = EB'(24); ph_nxt = pjhsp_pkg::PH_IDLE;
          end
        end
      end
      pjhsp_pkg::PH_SOI2: begin
        if (b == 8'hd8) begin
          ph_nxt = pjhsp_pkg::PH_SCAN;
        end else begin
          fail_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
        end
      end
      pjhsp_pkg::PH_SCAN: begin
        if (b == 8'hff) ph_nxt = pjhsp_pkg::PH_FILL;
      end
      pjhsp_pkg::PH_FILL: begin
        if (b == 8'hff) begin
          ph_nxt = pjhsp_pkg::PH_FILL;
        end else if (b == 8'hd9 || b == 8'hda) begin
          fail_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
        end else if (b == 8'h00 || b == 8'h01 || (b >= 8'hd0 && b <= 8'hd8)) begin
          ph_nxt = pjhsp_pkg::PH_SCAN;
        end else if (is_sof) begin
          ph_nxt = pjhsp_pkg::PH_SOF_LEN_HI;
        end else begin
          ph_nxt = pjhsp_pkg::PH_LEN_HI;
        end
      end
      pjhsp_pkg::PH_LEN_HI, pjhsp_pkg::PH_SOF_LEN_HI: begin
        left_nxt = {8'd0, b};
        end_nxt = EB'(cnt_r);
        ph_nxt = (ph_r == pjhsp_pkg::PH_LEN_HI) ? pjhsp_pkg::PH_LEN_LO
                                                 : pjhsp_pkg::PH_SOF_LEN_LO;
      end
      pjhsp_pkg::PH_LEN_LO: begin
        if (size < 16'd2) begin
          fail_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
        end else begin
          left_nxt = size - 16'd2;
          ph_nxt = (size == 16'd2) ? pjhsp_pkg::PH_SCAN : pjhsp_pkg::PH_SKIP;
        end
      end
      pjhsp_pkg::PH_SOF_LEN_LO: begin
        if (size < 16'd7) begin
          fail_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
        end else begin
          end_nxt = end_r + EB'(size);
          off_nxt = 3'd2; ph_nxt = pjhsp_pkg::PH_SOF_BODY;
        end
      end
      pjhsp_pkg::PH_SKIP: begin
        left_nxt = left_r - 16'd1;
        if (left_r == 16'd1) ph_nxt = pjhsp_pkg::PH_SCAN;
      end
      pjhsp_pkg::PH_SOF_BODY: begin
        if (off_r == 3'd3 || off_r == 3'd4) h_nxt = {h_r[23:0], b};
        else if (off_r >= 3'd5) w_nxt = {w_r[23:0], b};
        if (off_r >= 3'd6) begin
          found_nxt = 1'b1; ph_nxt = pjhsp_pkg::PH_IDLE;
        end else begin
          off_nxt = off_r + 3'd1;
        end
      end
      default: ph_nxt = ph_r;
    endcase
    if (cnt_r != CMAX) cnt_nxt = cnt_r + COUNT_BITS'(1);
  end

  assign cnt_ext = EB'(cnt_nxt);
  assign cnt_big = CW'(cnt_nxt);
  assign hdr_ok = !fail_nxt && found_nxt && (cnt_ext >= end_nxt) &&
                  (w_nxt != 32'd0) && (h_nxt != 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ph_r <= pjhsp_pkg::PH_START; fail_r <= 1'b0; found_r <= 1'b0;
      left_r <= '0; off_r <= '0; end_r <= '0; w_r <= '0; h_r <= '0; fmt_r <= '0;
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= fire && in_data.final_byte;
      if (fire) begin
        if (in_data.final_byte) begin
          cnt_r <= '0; ph_r <= pjhsp_pkg::PH_START; fail_r <= 1'b0; found_r <= 1'b0;
          left_r <= '0; off_r <= '0; end_r <= '0; w_r <= '0; h_r <= '0; fmt_r <= '0;
        end else begin
          cnt_r <= cnt_nxt; ph_r <= ph_nxt; fail_r <= fail_nxt; found_r <= found_nxt;
          left_r <= left_nxt; off_r <= off_nxt; end_r <= end_nxt;
          w_r <= w_nxt; h_r <= h_nxt; fmt_r <= fmt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_data.final_byte) begin
      sum_data.hdr_ok <= hdr_ok;
      sum_data.count_bad <= cnt_big > CW'(max_file_size);
      sum_data.fmt <= fmt_nxt;
      sum_data.width <= w_nxt;
      sum_data.height <= h_nxt;
    end
  end

endmodule

// ===== hw/rtl/pjhsp_checker.sv =====
module pjhsp_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  sum_valid,
  output logic                  sum_full,
  input  pjhsp_pkg::file_sum_t  sum_data,
  input  logic [31:0]           max_side,
  input  logic [47:0]           max_pixel_count,
  input  logic                  limits_bad,
  output logic                  out_empty,
  input  logic                  out_pop,
  output pjhsp_pkg::out_beat_t  out_data
);

  // Stage one registers the product, stage two forms the status, then a
  // four-entry queue holds results.
  logic                 s1_v_r;
  pjhsp_pkg::file_sum_t s1_r;
  logic [63:0]          prod_r;
  logic                 side_bad_r;
  pjhsp_pkg::out_beat_t q_r [4];
  logic [1:0]           rd_r, wr_r;
  logic [2:0]           cnt_r;
  pjhsp_pkg::out_beat_t res;
  logic                 push, pop;
  logic [2:0]           pend;

  assign pend = cnt_r + {2'b0, s1_v_r} + {2'b0, sum_valid};
  assign sum_full = pend >= 3'd4 && !(out_pop && !out_empty && pend == 3'd4);
  assign push = s1_v_r;
  assign pop = out_pop && !out_empty;
  assign out_empty = cnt_r == 3'd0;
  assign out_data = q_r[rd_r];

  always_comb begin
    res.image_format = s1_r.hdr_ok ? s1_r.fmt : pjhsp_pkg::FMT_UNKNOWN;
    if (limits_bad) res.status = pjhsp_pkg::ST_LIMITS;
    else if (s1_r.count_bad) res.status = pjhsp_pkg::ST_SIZE;
    else if (!s1_r.hdr_ok) res.status = pjhsp_pkg::ST_HEADER;
    else if (side_bad_r || prod_r > {16'd0, max_pixel_count}) res.status = pjhsp_pkg::ST_DIMS;
    else res.status = pjhsp_pkg::ST_OK;
    res.image_width = (res.status == pjhsp_pkg::ST_OK) ? s1_r.width : 32'd0;
    res.image_height = (res.status == pjhsp_pkg::ST_OK) ? s1_r.height : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; rd_r <= 2'd0; wr_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      s1_v_r <= sum_valid;
      if (push) wr_r <= wr_r + 2'd1;
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      s1_r <= sum_data;
      prod_r <= sum_data.width * sum_data.height;
      side_bad_r <= sum_data.width > max_side || sum_data.height > max_side;
    end
    if (push) q_r[wr_r] <= res;
  end

endmodule

// ===== hw/rtl/png_jpeg_header_size_probe_core.sv =====
// Image header size probe: takes a PNG or JPEG file one byte per beat, the
// last byte flagged, and gives one result beat per file with status, format,
// width and height. A byte is taken every cycle while results are drained; a
// result reaches the output ports through the parser summary register, the
// checker product register and the result queue. The input stalls only when
// the four-entry result queue, counting results still inside the checker, is
// full and no result leaves in that cycle.
module png_jpeg_header_size_probe_core #(
  parameter int COUNT_BITS = pjhsp_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  pjhsp_pkg::in_beat_t                   in_data,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output pjhsp_pkg::out_beat_t                  out_data,
  input  logic                                  cfg_we,
  input  logic [pjhsp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pjhsp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [31:0] max_file_size_r, max_side_r;
  logic [47:0] max_pixel_count_r;
  logic sum_valid, sum_full;
  pjhsp_pkg::file_sum_t sum_data;
  logic limits_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_file_size_r <= pjhsp_pkg::MAX_FILE_SIZE_RST;
      max_side_r <= pjhsp_pkg::MAX_SIDE_RST;
      max_pixel_count_r <= pjhsp_pkg::MAX_PIXEL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pjhsp_pkg::REG_MAX_FILE_SIZE: max_file_size_r <= cfg_data[31:0];
        pjhsp_pkg::REG_MAX_SIDE: max_side_r <= cfg_data[31:0];
        pjhsp_pkg::REG_MAX_PIXEL_COUNT: max_pixel_count_r <= cfg_data;
        default: max_side_r <= max_side_r;
      endcase
    end
  end

  assign limits_bad = max_file_size_r == 32'd0 || max_side_r == 32'd0 ||
                      max_pixel_count_r == 48'd0;

  pjhsp_parser #(.COUNT_BITS(COUNT_BITS)) u_parser (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .max_file_size(max_file_size_r),
    .sum_valid, .sum_full, .sum_data
  );

  pjhsp_checker u_checker (
    .clk, .rst_n, .sum_valid, .sum_full, .sum_data,
    .max_side(max_side_r), .max_pixel_count(max_pixel_count_r), .limits_bad,
    .out_empty, .out_pop, .out_data
  );

endmodule
